// ----- hw/rtl/arp_neighbor_table_learn_macros.svh -----
// ----------------------------------------------------------------------------
// ARP neighbor table assertion macros
// Shared concurrent assertion forms for the neighbor table learn block.
// ----------------------------------------------------------------------------
`ifndef ARP_NEIGHBOR_TABLE_LEARN_MACROS_SVH
`define ARP_NEIGHBOR_TABLE_LEARN_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ANTL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ANTL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/arp_ntl_pkg.sv -----
// ----------------------------------------------------------------------------
// ARP neighbor table package
// Widths, status codes, sequencer states and shared types.
// ----------------------------------------------------------------------------
package arp_ntl_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 16;
  localparam int unsigned IP_W              = 32;
  localparam int unsigned MAC_W             = 48;
  localparam int unsigned STATUS_W          = 3;

  localparam logic [7:0]       OCTET_ONES = 8'hff;
  localparam logic [MAC_W-1:0] MAC_ONES   = {6{OCTET_ONES}};

  typedef enum logic [STATUS_W-1:0] {
    ST_IGNORED   = 3'd0,
    ST_UNCHANGED = 3'd1,
    ST_UPDATED   = 3'd2,
    ST_ADDED     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic sender_bad;
    logic ip_eq;
    logic mac_eq;
  } match_res_t;

endpackage

// ----- hw/rtl/arp_ntl_ifs.sv -----
// ----------------------------------------------------------------------------
// ARP neighbor table channel interfaces
// Valid/ready channels for learned senders and learn results.
// ----------------------------------------------------------------------------
interface arp_ntl_in_if;
  logic                           valid;
  logic                           ready;
  logic [arp_ntl_pkg::IP_W-1:0]   sender_ip;
  logic [arp_ntl_pkg::MAC_W-1:0]  sender_mac;

  modport source (output valid, output sender_ip, output sender_mac, input ready);
  modport sink (input valid, input sender_ip, input sender_mac, output ready);
endinterface

interface arp_ntl_out_if;
  logic                              valid;
  logic                              ready;
  logic [arp_ntl_pkg::STATUS_W-1:0]  learn_status;

  modport source (output valid, output learn_status, input ready);
  modport sink (input valid, input learn_status, output ready);
endinterface

// ----- hw/rtl/arp_ntl_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module arp_ntl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/arp_ntl_match.sv -----
// ----------------------------------------------------------------------------
// ARP neighbor table compare unit
// Checks the sender and compares it against one table entry per cycle.
// ----------------------------------------------------------------------------
module arp_ntl_match (
  input  logic [arp_ntl_pkg::IP_W-1:0]  item_ip,
  input  logic [arp_ntl_pkg::MAC_W-1:0] item_mac,
  input  logic [arp_ntl_pkg::IP_W-1:0]  entry_ip,
  input  logic [arp_ntl_pkg::MAC_W-1:0] entry_mac,
  output arp_ntl_pkg::match_res_t       res
);

  always_comb begin
    res.sender_bad = (item_ip == '0) || (item_mac == '0) ||
                     (item_mac == arp_ntl_pkg::MAC_ONES);
    res.ip_eq      = (entry_ip == item_ip);
    res.mac_eq     = (entry_mac == item_mac);
  end

endmodule

// ----- hw/rtl/arp_ntl_ctrl.sv -----
// ----------------------------------------------------------------------------
// ARP neighbor table sequencer
// Walks the table in index order, tracks the first free entry and valid marks.
// ----------------------------------------------------------------------------
module arp_ntl_ctrl #(
  parameter int unsigned TABLE_ENTRIES = arp_ntl_pkg::TABLE_ENTRIES_DEF,
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_fire,
  output logic                      in_ready,
  input  arp_ntl_pkg::match_res_t   match,
  output logic                      rd_en,
  output logic [IDX_W-1:0]          rd_addr,
  output logic                      wr_en,
  output logic [IDX_W-1:0]          wr_addr,
  output logic                      res_vld,
  output arp_ntl_pkg::status_t      res_status,
  input  logic                      res_ready
);

  arp_ntl_pkg::ctrl_state_t state_r, state_nxt;
  arp_ntl_pkg::status_t     status_r, status_nxt;
  logic [CNT_W-1:0]         issue_cnt_r, issue_cnt_nxt;
  logic                     cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]         cmp_idx_r, cmp_idx_nxt;
  logic                     have_free_r, have_free_nxt;
  logic [IDX_W-1:0]         free_idx_r, free_idx_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic                     set_valid;
  logic [IDX_W-1:0]         issue_idx;
  logic                     issue_more;

  assign issue_idx  = issue_cnt_r[IDX_W-1:0];
  assign issue_more = (issue_cnt_r != CNT_W'(TABLE_ENTRIES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= arp_ntl_pkg::S_IDLE;
      status_r    <= arp_ntl_pkg::ST_IGNORED;
      issue_cnt_r <= '0;
      cmp_vld_r   <= 1'b0;
      cmp_idx_r   <= '0;
      have_free_r <= 1'b0;
      free_idx_r  <= '0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      issue_cnt_r <= issue_cnt_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      cmp_idx_r   <= cmp_idx_nxt;
      have_free_r <= have_free_nxt;
      free_idx_r  <= free_idx_nxt;
      if (set_valid) begin
        valid_r[free_idx_r] <= 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    status_nxt    = status_r;
    issue_cnt_nxt = issue_cnt_r;
    cmp_vld_nxt   = cmp_vld_r;
    cmp_idx_nxt   = cmp_idx_r;
    have_free_nxt = have_free_r;
    free_idx_nxt  = free_idx_r;
    in_ready      = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = issue_idx;
    wr_en         = 1'b0;
    wr_addr       = cmp_idx_r;
    set_valid     = 1'b0;
    res_vld       = 1'b0;
    unique case (state_r)
      arp_ntl_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          state_nxt = arp_ntl_pkg::S_CHECK;
        end
      end
      arp_ntl_pkg::S_CHECK: begin
        if (match.sender_bad) begin
          status_nxt = arp_ntl_pkg::ST_IGNORED;
          state_nxt  = arp_ntl_pkg::S_DONE;
        end else begin
          issue_cnt_nxt = '0;
          have_free_nxt = 1'b0;
          cmp_vld_nxt   = 1'b0;
          state_nxt     = arp_ntl_pkg::S_SCAN;
        end
      end
      arp_ntl_pkg::S_SCAN: begin
        cmp_vld_nxt = 1'b0;
        if (cmp_vld_r && match.ip_eq) begin
          if (match.mac_eq) begin
            status_nxt = arp_ntl_pkg::ST_UNCHANGED;
          end else begin
            wr_en      = 1'b1;
            wr_addr    = cmp_idx_r;
            status_nxt = arp_ntl_pkg::ST_UPDATED;
          end
          state_nxt = arp_ntl_pkg::S_DONE;
        end else if (issue_more) begin
          rd_en         = 1'b1;
          cmp_vld_nxt   = valid_r[issue_idx];
          cmp_idx_nxt   = issue_idx;
          issue_cnt_nxt = issue_cnt_r + 1'b1;
          if (!valid_r[issue_idx] && !have_free_r) begin
            have_free_nxt = 1'b1;
            free_idx_nxt  = issue_idx;
          end
        end else begin
          if (have_free_r) begin
            wr_en      = 1'b1;
            wr_addr    = free_idx_r;
            set_valid  = 1'b1;
            status_nxt = arp_ntl_pkg::ST_ADDED;
          end else begin
            status_nxt = arp_ntl_pkg::ST_FULL;
          end
          state_nxt = arp_ntl_pkg::S_DONE;
        end
      end
      arp_ntl_pkg::S_DONE: begin
        res_vld = 1'b1;
        if (res_ready) begin
          state_nxt = arp_ntl_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = arp_ntl_pkg::S_IDLE;
      end
    endcase
  end

  assign res_status = status_r;

endmodule

// ----- hw/rtl/arp_neighbor_table_learn.sv -----
// ----------------------------------------------------------------------------
// ARP neighbor table, learn path
// Learns (IPv4, MAC) senders into a fixed table with no eviction.
// ----------------------------------------------------------------------------
// Each beat on in_chan carries one sender IP and MAC; each beat on out_chan
// carries one learn status (ignored, unchanged, updated, added, table full).
// The table sits in a single-port-write RAM with a registered read port, so
// the sequencer reads one entry per cycle and a shared compare unit checks it
// in the following cycle. Valid marks are flip-flops cleared at reset, so the
// table is usable as soon as reset ends, with no clearing pass. An ignored
// sender goes from the check state straight to the done state with no scan.
// A scan reads the entries in index order, bounded by the one read per cycle
// of the table RAM; a match ends the scan early. The block takes one sender
// at a time. A finished result moves into the output register and the next
// sender can be accepted while it waits; if the receiver stalls longer, the
// following result holds the block busy.
// ----------------------------------------------------------------------------
`include "arp_neighbor_table_learn_macros.svh"

module arp_neighbor_table_learn #(
  parameter int unsigned TABLE_ENTRIES = arp_ntl_pkg::TABLE_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  arp_ntl_in_if.sink    in_chan,
  arp_ntl_out_if.source out_chan
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned ENT_W = arp_ntl_pkg::IP_W + arp_ntl_pkg::MAC_W;

  logic [arp_ntl_pkg::IP_W-1:0]  item_ip_r;
  logic [arp_ntl_pkg::MAC_W-1:0] item_mac_r;
  logic                          in_ready;
  logic                          in_fire;
  arp_ntl_pkg::match_res_t       match;
  logic                          rd_en;
  logic [IDX_W-1:0]              rd_addr;
  logic                          wr_en;
  logic [IDX_W-1:0]              wr_addr;
  logic [ENT_W-1:0]              rd_data;
  logic                          res_vld;
  arp_ntl_pkg::status_t          res_status;
  logic                          res_ready;
  logic                          out_valid_r;
  arp_ntl_pkg::status_t          out_status_r;

  assign in_chan.ready = in_ready;
  assign in_fire       = in_chan.valid && in_ready;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_ip_r  <= in_chan.sender_ip;
      item_mac_r <= in_chan.sender_mac;
    end
  end

  arp_ntl_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata ({item_ip_r, item_mac_r}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  arp_ntl_match u_match (
    .item_ip   (item_ip_r),
    .item_mac  (item_mac_r),
    .entry_ip  (rd_data[ENT_W-1:arp_ntl_pkg::MAC_W]),
    .entry_mac (rd_data[arp_ntl_pkg::MAC_W-1:0]),
    .res       (match)
  );

  arp_ntl_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_ready   (in_ready),
    .match      (match),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .res_vld    (res_vld),
    .res_status (res_status),
    .res_ready  (res_ready)
  );

  assign res_ready = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld && res_ready) begin
      out_status_r <= res_status;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.learn_status = out_status_r;

  `ANTL_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, !in_ready,
    "block still ready the cycle after accepting a beat")
  `ANTL_ASSERT_NOW(a_no_result_while_open, clk, rst_n, res_vld, !in_ready,
    "result offered while the block is open for input")
  `ANTL_ASSERT_NEXT(a_result_loaded, clk, rst_n, res_vld && res_ready,
    out_valid_r && (out_status_r == $past(res_status)),
    "finished result not loaded into the output register")

endmodule

// ----- test/tb_arp_neighbor_table_learn.sv -----
// ----------------------------------------------------------------------------
// ARP neighbor table learn testbench
// Drives learned senders through the input channel in bursts and checks every
// learn status beat against a scoreboard that keeps its own copy of the table.
// A directed opening fills the table and hits each status; random traffic then
// mixes known neighbors, fresh addresses and malformed senders, while the
// result channel stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb_arp_neighbor_table_learn;
  timeunit 1ns;
  timeprecision 1ps;

  import arp_ntl_pkg::*;

  localparam int unsigned POOL_SIZE    = 24;
  localparam int unsigned MAC_CHOICES  = 3;
  localparam int unsigned RANDOM_ITEMS = 1950;
  localparam int unsigned DRAIN_CYCLES = TABLE_ENTRIES_DEF + 8;

  class learn_scoreboard;
    bit               entry_valid [TABLE_ENTRIES_DEF];
    logic [IP_W-1:0]  entry_ip    [TABLE_ENTRIES_DEF];
    logic [MAC_W-1:0] entry_mac   [TABLE_ENTRIES_DEF];
    status_t          status_q [$];
    int unsigned      status_count [5];
    int unsigned      errors;
    int unsigned      checked;

    function void learn_sender(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
      status_t st;
      int      free_idx;
      bit      hit;
      free_idx = -1;
      hit      = 1'b0;
      st       = ST_IGNORED;
      if (ip != '0 && mac != '0 && mac != MAC_ONES) begin
        for (int i = 0; i < TABLE_ENTRIES_DEF && !hit; i++) begin
          if (!entry_valid[i]) begin
            if (free_idx < 0) free_idx = i;
          end else if (entry_ip[i] == ip) begin
            hit = 1'b1;
            if (entry_mac[i] == mac) begin
              st = ST_UNCHANGED;
            end else begin
              entry_mac[i] = mac;
              st = ST_UPDATED;
            end
          end
        end
        if (!hit) begin
          if (free_idx >= 0) begin
            entry_valid[free_idx] = 1'b1;
            entry_ip[free_idx]    = ip;
            entry_mac[free_idx]   = mac;
            st = ST_ADDED;
          end else begin
            st = ST_FULL;
          end
        end
      end
      status_count[int'(st)]++;
      status_q.push_back(st);
    endfunction

    function void check_status(input logic [STATUS_W-1:0] got);
      status_t want;
      if (status_q.size() == 0) begin
        $error("learn_status beat with no expected result: actual %0d", got);
        errors++;
        return;
      end
      want = status_q.pop_front();
      checked++;
      if (got !== want) begin
        $error("learn_status mismatch: expected %0d (%s), actual %0d", want, want.name(), got);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return status_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  arp_ntl_in_if  in_chan ();
  arp_ntl_out_if out_chan ();

  arp_neighbor_table_learn u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  learn_scoreboard sb = new();

  logic [IP_W-1:0]  ip_pool  [POOL_SIZE];
  logic [MAC_W-1:0] mac_pool [POOL_SIZE][MAC_CHOICES];
  int unsigned      burst_left;
  int unsigned      sent;
  int unsigned      rx_mode;
  int unsigned      rx_left;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic send_sender(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
    in_chan.valid      <= 1'b1;
    in_chan.sender_ip  <= ip;
    in_chan.sender_mac <= mac;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sb.learn_sender(ip, mac);
    sent++;
    if (burst_left == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    out_chan.ready <= 1'b0;
    rx_left = 0;
    rx_mode = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) sb.check_status(out_chan.learn_status);
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      case (rx_mode)
        0: begin
          out_chan.ready <= 1'b1;
        end
        1: begin
          out_chan.ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          out_chan.ready <= ($urandom_range(0, 7) == 0);
        end
      endcase
    end
  end

  initial begin
    bit                dup;
    int unsigned       idx;
    int unsigned       pick;
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;

    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.sender_ip  <= '0;
    in_chan.sender_mac <= '0;
    burst_left = 4;
    sent       = 0;

    ip_pool[0] = 32'hffff_ffff;
    ip_pool[1] = 32'h0000_0001;
    for (int i = 2; i < POOL_SIZE; i++) begin
      do begin
        ip_pool[i] = $urandom;
        dup = (ip_pool[i] == '0);
        for (int j = 0; j < i; j++) if (ip_pool[j] == ip_pool[i]) dup = 1'b1;
      end while (dup);
    end
    for (int i = 0; i < POOL_SIZE; i++) begin
      for (int k = 0; k < MAC_CHOICES; k++) mac_pool[i][k] = {16'($urandom), $urandom};
    end
    mac_pool[0][0] = 48'h0000_0000_0001;
    mac_pool[0][1] = 48'hffff_ffff_fffe;
    mac_pool[1][0] = 48'h8000_0000_0000;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_sender('0, {16'($urandom), $urandom});
    send_sender(32'hffff_ffff, '0);
    send_sender($urandom, MAC_ONES);
    send_sender('0, '0);
    send_sender(ip_pool[0], mac_pool[0][0]);
    send_sender(ip_pool[0], mac_pool[0][0]);
    send_sender(ip_pool[0], mac_pool[0][1]);
    send_sender(ip_pool[1], mac_pool[1][0]);
    send_sender(ip_pool[1], MAC_ONES);
    for (int i = 2; i < TABLE_ENTRIES_DEF; i++) send_sender(ip_pool[i], mac_pool[i][0]);
    send_sender(ip_pool[TABLE_ENTRIES_DEF], mac_pool[TABLE_ENTRIES_DEF][0]);
    send_sender(ip_pool[0], mac_pool[0][1]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        idx = $urandom_range(0, POOL_SIZE - 1);
        ip  = ip_pool[idx];
        mac = mac_pool[idx][$urandom_range(0, MAC_CHOICES - 1)];
      end else if (pick < 85) begin
        ip  = $urandom;
        mac = {16'($urandom), $urandom};
      end else begin
        ip  = ($urandom_range(0, 1) == 0) ? ip_pool[$urandom_range(0, POOL_SIZE - 1)]
                                          : 32'($urandom);
        mac = {16'($urandom), $urandom};
        case ($urandom_range(0, 2))
          0: ip  = '0;
          1: mac = '0;
          default: mac = MAC_ONES;
        endcase
      end
      send_sender(ip, mac);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d senders and checked %0d learn results.", sent, sb.checked);
    $display("Mix: ignored %0d, unchanged %0d, updated %0d, added %0d, full %0d.",
             sb.status_count[ST_IGNORED], sb.status_count[ST_UNCHANGED],
             sb.status_count[ST_UPDATED], sb.status_count[ST_ADDED],
             sb.status_count[ST_FULL]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Timeout with %0d learn results outstanding.", sb.pending());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
